// ===== hw/rtl/ltok_pkg.sv =====
// ----------------------------------------------------------------------------
// ltok_pkg: shared types and character classes for the line tokenizer
// Token kinds, lexing modes, result and step records, byte classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ltok_pkg;

  localparam int unsigned ColW  = 12;  // column field on the result word
  localparam int unsigned LineW = 16;  // line field on the result word

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChAt    = 8'h40;

  typedef enum logic [2:0] {
    K_STRING    = 3'd0,
    K_INTEGER   = 3'd1,
    K_IDENT     = 3'd2,
    K_DIRECTIVE = 3'd3,
    K_SYMBOL    = 3'd4,
    K_OPERATOR  = 3'd5,
    K_EOL       = 3'd6
  } tok_kind_e;

  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_STRING    = 3'd1,
    M_INTEGER   = 3'd2,
    M_NAME      = 3'd3,
    M_DIRECTIVE = 3'd4,
    M_OPERATOR  = 3'd5,
    M_COMMENT   = 3'd6
  } lex_mode_e;

  typedef struct packed {
    logic digit;
    logic bracket;
    logic symbol;
    logic oper;
    logic space;
    logic at;
    logic quote;
    logic slash;
    logic name;
  } char_class_t;

  // One result word, as it sits in the output queue.
  typedef struct packed {
    logic              last;
    logic [ColW-1:0]   column;
    logic [LineW-1:0]  line;
    logic [7:0]        data_byte;
    logic              has_byte;
    logic              start;
    tok_kind_e         kind;
  } result_t;

  // Up to two result words produced by one input word.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Outcome of handling one byte in a given mode.
  typedef struct packed {
    logic            emit;
    tok_kind_e       kind;
    logic            start;
    logic            has_byte;
    logic [7:0]      data_byte;
    logic [ColW-1:0] column;
    lex_mode_e       mode;
    logic [ColW-1:0] tok_col;
    logic            slash_set;
  } step_t;

  function automatic char_class_t classify(input logic [7:0] b);
    char_class_t c;
    c = '0;
    c.digit = (b >= 8'h30) && (b <= 8'h39);
    case (b) inside
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: c.bracket = 1'b1;
      8'h3B, 8'h2C, 8'h3A:                      c.symbol  = 1'b1;
      8'h7C, 8'h3C, 8'h3E, 8'h2B, 8'h3D, 8'h2D, 8'h2A,
      8'h26, 8'h25, 8'h21, 8'h7E, 8'h3F, 8'h2F, 8'h2E: c.oper = 1'b1;
      8'h20, 8'h09, 8'h0A:                      c.space   = 1'b1;
      default: ;
    endcase
    c.at    = (b == ChAt);
    c.quote = (b == ChQuote);
    c.slash = (b == ChSlash);
    c.name  = !(c.bracket || c.symbol || c.oper || c.space || c.at);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ltok_byte_step.sv =====
// ----------------------------------------------------------------------------
// ltok_byte_step: one byte through the lexing mode
// Continues the open token or falls back to between-token handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ltok_byte_step (
  input  ltok_pkg::lex_mode_e           mode_i,
  input  logic [ltok_pkg::ColW-1:0]     tok_col_i,
  input  logic [7:0]                    byte_i,
  input  logic [ltok_pkg::ColW-1:0]     col_i,
  output ltok_pkg::step_t               step_o
);
  import ltok_pkg::*;

  char_class_t cls;
  logic        go_idle;
  step_t       st;

  assign cls = classify(byte_i);

  always_comb begin
    st           = '0;
    st.kind      = K_STRING;
    st.has_byte  = 1'b1;
    st.data_byte = byte_i;
    st.column    = tok_col_i;
    st.mode      = mode_i;
    st.tok_col   = tok_col_i;
    go_idle      = 1'b0;

    unique case (mode_i)
      M_COMMENT: ;
      M_STRING: begin
        if (cls.quote) begin
          st.mode = M_IDLE;
        end else begin
          st.emit = 1'b1;
          st.kind = K_STRING;
        end
      end
      M_INTEGER: begin
        st.emit = cls.digit;
        st.kind = K_INTEGER;
        go_idle = !cls.digit;
      end
      M_NAME: begin
        st.emit = cls.name;
        st.kind = K_IDENT;
        go_idle = !cls.name;
      end
      M_DIRECTIVE: begin
        st.emit = cls.name;
        st.kind = K_DIRECTIVE;
        go_idle = !cls.name;
      end
      M_OPERATOR: begin
        st.emit = cls.oper;
        st.kind = K_OPERATOR;
        go_idle = !cls.oper;
      end
      default: go_idle = 1'b1;
    endcase

    // between tokens: '/' is held, white space dropped, anything else opens
    if (go_idle) begin
      st.emit = 1'b0;
      st.mode = M_IDLE;
      if (cls.slash) begin
        st.slash_set = 1'b1;
      end else if (!cls.space) begin
        st.emit    = 1'b1;
        st.start   = 1'b1;
        st.column  = col_i;
        st.tok_col = col_i;
        if (cls.quote) begin
          st.kind      = K_STRING;
          st.has_byte  = 1'b0;
          st.data_byte = 8'h00;
          st.mode      = M_STRING;
        end else if (cls.digit) begin
          st.kind = K_INTEGER;
          st.mode = M_INTEGER;
        end else if (cls.bracket || cls.symbol) begin
          st.kind = K_SYMBOL;
        end else if (cls.oper) begin
          st.kind = K_OPERATOR;
          st.mode = M_OPERATOR;
        end else if (cls.at) begin
          st.kind      = K_DIRECTIVE;
          st.has_byte  = 1'b0;
          st.data_byte = 8'h00;
          st.mode      = M_DIRECTIVE;
        end else begin
          st.kind = K_IDENT;
          st.mode = M_NAME;
        end
      end
    end
  end

  assign step_o = st;

endmodule

`default_nettype wire

// ===== hw/rtl/ltok_lexer.sv =====
// ----------------------------------------------------------------------------
// ltok_lexer: lexing state and result building
// Holds mode, held slash and counters; turns one word into 0..2 results.
// ----------------------------------------------------------------------------
`default_nettype none

module ltok_lexer #(
  parameter int unsigned COLUMN_BITS = 12,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_line_i,
  output ltok_pkg::push_t   push_o
);
  import ltok_pkg::*;

  lex_mode_e              mode_q, mode_d;
  logic                   slash_q, slash_d;
  logic [ColW-1:0]        held_col_q, held_col_d;
  logic [ColW-1:0]        tok_col_q, tok_col_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   nonempty_q, nonempty_d;

  logic [ColW-1:0]  col_sat;
  logic [LineW-1:0] line_sat;
  lex_mode_e        step_mode;
  logic [ColW-1:0]  step_tok_col;
  step_t            step;
  result_t          slash_res, eol_res, step_res;
  push_t            push;

  // counters saturate at their own width; the result fields saturate again
  if (COLUMN_BITS > ColW) begin : g_col_wide
    assign col_sat = (|col_q[COLUMN_BITS-1:ColW]) ? '1 : col_q[ColW-1:0];
  end else begin : g_col_narrow
    assign col_sat = ColW'(col_q);
  end

  if (LINE_BITS > LineW) begin : g_line_wide
    assign line_sat = (|line_q[LINE_BITS-1:LineW]) ? '1 : line_q[LineW-1:0];
  end else begin : g_line_narrow
    assign line_sat = LineW'(line_q);
  end

  // a held slash that is not doubled starts an operator run at its column
  assign step_mode    = slash_q ? M_OPERATOR : mode_q;
  assign step_tok_col = slash_q ? held_col_q : tok_col_q;

  ltok_byte_step u_step (
    .mode_i    (step_mode),
    .tok_col_i (step_tok_col),
    .byte_i    (text_byte_i),
    .col_i     (col_sat),
    .step_o    (step)
  );

  always_comb begin
    slash_res           = '0;
    slash_res.kind      = K_OPERATOR;
    slash_res.start     = 1'b1;
    slash_res.has_byte  = 1'b1;
    slash_res.data_byte = ChSlash;
    slash_res.line      = line_sat;
    slash_res.column    = held_col_q;

    eol_res        = '0;
    eol_res.kind   = K_EOL;
    eol_res.start  = 1'b1;
    eol_res.line   = line_sat;
    eol_res.column = col_sat;

    step_res           = '0;
    step_res.kind      = step.kind;
    step_res.start     = step.start;
    step_res.has_byte  = step.has_byte;
    step_res.data_byte = step.data_byte;
    step_res.line      = line_sat;
    step_res.column    = step.column;
  end

  always_comb begin
    push       = '0;
    mode_d     = mode_q;
    slash_d    = slash_q;
    held_col_d = held_col_q;
    tok_col_d  = tok_col_q;
    line_d     = line_q;
    col_d      = col_q;
    nonempty_d = nonempty_q;

    if (end_of_line_i) begin
      push.first  = slash_q ? slash_res : eol_res;
      push.second = eol_res;
      push.count  = 2'({1'b0, slash_q} + {1'b0, nonempty_q});
      if (line_q != '1) begin
        line_d = line_q + LINE_BITS'(1);
      end
      col_d      = '0;
      mode_d     = M_IDLE;
      slash_d    = 1'b0;
      nonempty_d = 1'b0;
      if (slash_q) begin
        tok_col_d = held_col_q;
      end
    end else begin
      nonempty_d = 1'b1;
      if (col_q != '1) begin
        col_d = col_q + COLUMN_BITS'(1);
      end
      if (slash_q && (text_byte_i == ChSlash)) begin
        // comment to end of line
        mode_d  = M_COMMENT;
        slash_d = 1'b0;
      end else begin
        mode_d    = step.mode;
        tok_col_d = step.tok_col;
        slash_d   = step.slash_set;
        if (step.slash_set) begin
          held_col_d = col_sat;
        end
        if (slash_q) begin
          push.first  = slash_res;
          push.second = step_res;
          push.count  = step.emit ? 2'd2 : 2'd1;
        end else begin
          push.first  = step_res;
          push.second = step_res;
          push.count  = {1'b0, step.emit};
        end
      end
    end

    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      slash_q    <= 1'b0;
      held_col_q <= '0;
      tok_col_q  <= '0;
      line_q     <= LINE_BITS'(1);
      col_q      <= '0;
      nonempty_q <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      slash_q    <= slash_d;
      held_col_q <= held_col_d;
      tok_col_q  <= tok_col_d;
      line_q     <= line_d;
      col_q      <= col_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ltok_result_fifo.sv =====
// ----------------------------------------------------------------------------
// ltok_result_fifo: four-entry result queue
// Takes up to two result words per cycle, hands out one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ltok_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_en_i,
  input  ltok_pkg::push_t     push_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ltok_pkg::result_t   data_o
);
  import ltok_pkg::*;

  localparam int unsigned Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] push_n;
  logic [1:0] wr_next;
  logic       pop;

  assign push_n  = push_en_i ? push_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_ptr_q + 2'd1;

  assign room_o  = (count_q <= 3'd2);
  assign valid_o = (count_q != 3'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// line_tokenizer_unit: byte-stream source tokenizer
// Throughput: one word per cycle while the result queue has room for two more
// results, as it keeps with the output ready and at most one result per word;
// the four-entry result queue absorbs words with two results. Reset clears
// mode, held slash and counters (line 1, column 0) and empties the queue; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module line_tokenizer_unit #(
  parameter int unsigned COLUMN_BITS = 12,  // column counter width, 4..16
  parameter int unsigned LINE_BITS   = 16   // line counter width, 8..32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tuser_i,   // [0] end_of_line
  // result words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] out_byte, [23:8] line_index,
                                        // [35:24] column_index, [39:36] zero
  output logic [4:0]  m_axis_tuser_o,   // [2:0] token_kind, [3] token_start,
                                        // [4] has_byte
  output logic        m_axis_tlast_o    // last result of the input word
);
  import ltok_pkg::*;

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  // A word is taken whenever the queue has space for two more results,
  // so the lexer never has to stall mid-word.
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  // Lexer: all per-word work is combinational off the port and the state
  // registers; results land directly in the queue.
  ltok_lexer #(
    .COLUMN_BITS (COLUMN_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (s_axis_tdata_i),
    .end_of_line_i (s_axis_tuser_i),
    .push_o        (push)
  );

  // Result queue doubles as output register and skid stage.
  ltok_result_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (accept),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .data_o    (head)
  );

  assign m_axis_tdata_o = {4'b0000, head.column, head.line, head.data_byte};
  assign m_axis_tuser_o = {head.has_byte, head.start, head.kind};
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_tokenizer_unit
// Feeds source text and end-of-line words and predicts every token word in
// the bench. Each result word is checked field by field against the oldest
// prediction. Covers directed cases and random source lines.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ltok_pkg::*;

  localparam int unsigned RANDOM_WORDS = 370;
  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 38;

  typedef enum logic [2:0] {
    CC_SPACE, CC_DIGIT, CC_PUNCT, CC_OPER, CC_AT, CC_QUOTE, CC_NAME
  } char_kind_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_user  = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic [4:0]  m_user;
  logic        m_last;

  bit          steady = 1'b0;   // no idling on either side while set
  int          errors = 0;
  int unsigned sent_words = 0;
  int unsigned quiet_cycles = 0;

  // Lexer state as seen by the prediction
  lex_mode_e   lx_mode    = M_IDLE;
  logic        slash_wait = 1'b0;
  logic [11:0] slash_col  = '0;
  logic [11:0] token_col  = '0;
  logic [15:0] line_no    = 16'd1;
  logic [11:0] col_no     = '0;
  logic        line_used  = 1'b0;
  int unsigned made;

  result_t expected_tokens[$];

  line_tokenizer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic char_kind_e char_kind(logic [7:0] b);
    char_kind_e k;
    case (b)
      8'h20, 8'h09, 8'h0A:                          k = CC_SPACE;
      "(", ")", "[", "]", "{", "}", ";", ",", ":":  k = CC_PUNCT;
      "|", "<", ">", "+", "=", "-", "*", "&", "%",
      "!", "~", "?", "/", ".":                      k = CC_OPER;
      ChAt:                                         k = CC_AT;
      ChQuote:                                      k = CC_QUOTE;
      default: k = (b >= "0" && b <= "9") ? CC_DIGIT : CC_NAME;
    endcase
    return k;
  endfunction

  // digits and quotes count as name characters inside identifiers
  function automatic logic name_char(logic [7:0] b);
    char_kind_e k;
    k = char_kind(b);
    return (k == CC_DIGIT) || (k == CC_QUOTE) || (k == CC_NAME);
  endfunction

  function automatic void push_token(tok_kind_e kind, logic start, logic hasb,
                                     logic [7:0] b, logic [11:0] col);
    result_t r;
    r.kind      = kind;
    r.start     = start;
    r.has_byte  = hasb;
    r.data_byte = hasb ? b : 8'h00;
    r.line      = line_no;
    r.column    = col;
    r.last      = 1'b0;
    expected_tokens.insert(expected_tokens.size(), r);
    made++;
  endfunction

  // byte seen between tokens
  function automatic void start_token(logic [7:0] b, logic [11:0] col);
    char_kind_e k;
    k = char_kind(b);
    if (b == ChSlash) begin
      slash_wait = 1'b1;
      slash_col  = col;
    end else if (k != CC_SPACE) begin
      token_col = col;
      case (k)
        CC_QUOTE: begin
          lx_mode = M_STRING;
          push_token(K_STRING, 1'b1, 1'b0, b, col);
        end
        CC_DIGIT: begin
          lx_mode = M_INTEGER;
          push_token(K_INTEGER, 1'b1, 1'b1, b, col);
        end
        CC_PUNCT: push_token(K_SYMBOL, 1'b1, 1'b1, b, col);
        CC_OPER: begin
          lx_mode = M_OPERATOR;
          push_token(K_OPERATOR, 1'b1, 1'b1, b, col);
        end
        CC_AT: begin
          lx_mode = M_DIRECTIVE;
          push_token(K_DIRECTIVE, 1'b1, 1'b0, b, col);
        end
        default: begin
          lx_mode = M_NAME;
          push_token(K_IDENT, 1'b1, 1'b1, b, col);
        end
      endcase
    end
  endfunction

  // byte in the current mode; a byte that ends a token restarts between tokens
  function automatic void feed_byte(logic [7:0] b, logic [11:0] col);
    logic taken;
    taken = 1'b0;
    case (lx_mode)
      M_COMMENT: taken = 1'b1;
      M_STRING: begin
        taken = 1'b1;
        if (b == ChQuote) lx_mode = M_IDLE;
        else push_token(K_STRING, 1'b0, 1'b1, b, token_col);
      end
      M_INTEGER: if (char_kind(b) == CC_DIGIT) begin
        taken = 1'b1;
        push_token(K_INTEGER, 1'b0, 1'b1, b, token_col);
      end
      M_NAME: if (name_char(b)) begin
        taken = 1'b1;
        push_token(K_IDENT, 1'b0, 1'b1, b, token_col);
      end
      M_DIRECTIVE: if (name_char(b)) begin
        taken = 1'b1;
        push_token(K_DIRECTIVE, 1'b0, 1'b1, b, token_col);
      end
      M_OPERATOR: if (char_kind(b) == CC_OPER) begin
        taken = 1'b1;
        push_token(K_OPERATOR, 1'b0, 1'b1, b, token_col);
      end
      default: ;
    endcase
    if (!taken) begin
      lx_mode = M_IDLE;
      start_token(b, col);
    end
  endfunction

  function automatic void tokenize_word(logic [7:0] b, logic eol);
    logic [11:0] col;
    made = 0;
    if (eol) begin
      // a held slash is flushed as a lone operator
      if (slash_wait) begin
        token_col = slash_col;
        push_token(K_OPERATOR, 1'b1, 1'b1, ChSlash, slash_col);
      end
      if (line_used) push_token(K_EOL, 1'b1, 1'b0, 8'h00, col_no);
      if (line_no != '1) line_no++;
      col_no     = '0;
      lx_mode    = M_IDLE;
      slash_wait = 1'b0;
      line_used  = 1'b0;
    end else begin
      col       = col_no;
      line_used = 1'b1;
      if (col_no != '1) col_no++;
      if (slash_wait) begin
        slash_wait = 1'b0;
        if (b == ChSlash) begin
          lx_mode = M_COMMENT;
        end else begin
          token_col = slash_col;
          lx_mode   = M_OPERATOR;
          push_token(K_OPERATOR, 1'b1, 1'b1, ChSlash, slash_col);
          feed_byte(b, col);
        end
      end else begin
        feed_byte(b, col);
      end
    end
    if (made != 0) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_word(input logic [7:0] b, input logic eol);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= eol;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    tokenize_word(b, eol);
    sent_words++;
  endtask

  task automatic send_line(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_word(txt[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  always @(posedge clk_i) m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (m_valid && m_ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: word with nothing expected, actual tdata %h tuser %h tlast %b",
                 $time, m_data, m_user, m_last);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind",   16'(want.kind),      16'(m_user[2:0]));
        check_field("token_start",  16'(want.start),     16'(m_user[3]));
        check_field("has_byte",     16'(want.has_byte),  16'(m_user[4]));
        check_field("out_byte",     16'(want.data_byte), 16'(m_data[7:0]));
        check_field("line_index",   want.line,           m_data[23:8]);
        check_field("column_index", 16'(want.column),    16'(m_data[35:24]));
        check_field("tdata pad",    16'h0,               16'(m_data[39:36]));
        check_field("tlast",        16'(want.last),      16'(m_last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("line_tokenizer_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // every kind, closed and open strings, comment, held slash, empty line,
  // operator run ended by a name byte, zero and all-ones bytes
  task automatic test_directed();
    send_line("\"a\"7x/=b");
    send_line("@9\"(;//z");
    send_word(8'hFF, 1'b1);          // empty line, stray byte ignored
    send_line("\"q");                // string still open at end of line
    send_line("/");                  // held slash flushed at end of line
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h09, 1'b0);
    send_word("}", 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  // mostly well-formed token fragments, some raw bytes and broken strings
  task automatic test_random_source();
    int unsigned first;
    int unsigned n;
    first = sent_words;
    while (sent_words - first < RANDOM_WORDS) begin
      steady = (sent_words - first >= 150) && (sent_words - first < 260);
      case ($urandom_range(11))
        0, 1: begin
          send_word(pick("abqXZ_$"), 1'b0);
          n = $urandom_range(4);
          repeat (n) send_word(pick("az09_\"Q"), 1'b0);
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) send_word(pick("0123456789"), 1'b0);
        end
        3: begin
          send_word(ChQuote, 1'b0);
          n = $urandom_range(3);
          repeat (n) send_word(pick("a b;/9@"), 1'b0);
          if ($urandom_range(9) < 7) send_word(ChQuote, 1'b0);
        end
        4: begin
          send_word(ChAt, 1'b0);
          n = $urandom_range(3);
          repeat (n) send_word(pick("aZ7_"), 1'b0);
        end
        5: send_word(pick("()[]{};,:"), 1'b0);
        6, 7: begin
          n = $urandom_range(1, 3);
          repeat (n) send_word(pick("|<>+=-*&%!~?/."), 1'b0);
        end
        8: begin
          send_word(ChSlash, 1'b0);
          send_word(ChSlash, 1'b0);
          n = $urandom_range(3);
          repeat (n) send_word(8'($urandom_range(255)), 1'b0);
        end
        9: send_word(8'($urandom_range(255)), 1'b0);
        default: send_word(8'($urandom_range(255)), 1'b1);
      endcase
      if ($urandom_range(1) == 0) send_word(pick(" \t\n"), 1'b0);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_source();
    s_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("line_tokenizer_unit: match");
    else $display("line_tokenizer_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
